// File: design/srlg_pkg.sv
// ----------------------------------------------------------------------------
// srlg_pkg
// Shared types, constants and helpers for the scaled linear ramp generator.
// ----------------------------------------------------------------------------
package srlg_pkg;

  localparam int unsigned WordBits  = 32;
  localparam int unsigned ValueBits = 31;
  localparam int unsigned StepBits  = 23;
  localparam int unsigned ExpBits   = 5;
  localparam int unsigned RateBits  = 16;
  localparam int unsigned MsBits    = 16;
  localparam int unsigned TopExp    = 31;
  localparam int unsigned MsPerS    = 1000;

  // x/1000 for any 32-bit x: multiply by ceil(2^38/1000), keep bits 38 and up
  localparam int unsigned          RecipBits  = 29;
  localparam int unsigned          RecipShift = 38;
  localparam logic [RecipBits-1:0] RecipMs    = RecipBits'(274877907);

  localparam logic [RateBits-1:0] RateReset = RateBits'(16000);

  // most negative target and the value it saturates to
  localparam logic [ValueBits-1:0] TargetMin = {1'b1, {(ValueBits-1){1'b0}}};
  localparam logic [ValueBits-1:0] TargetSat = {1'b1, {(ValueBits-2){1'b0}}, 1'b1};

  typedef enum logic [1:0] {
    KindTick  = 2'd0,
    KindStart = 2'd1,
    KindStop  = 2'd2,
    KindNone  = 2'd3
  } kind_e;

  // classified command word
  typedef struct packed {
    kind_e                        kind;
    logic                         jump;    // start with zero duration
    logic signed [ValueBits-1:0]  target;  // already saturated
    logic [MsBits-1:0]            ms;
  } cmd_t;

  typedef struct packed {
    logic                 start;
    logic [WordBits-1:0]  dividend;
    logic [StepBits-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [WordBits-1:0]  quot;
  } div_rsp_t;

  // accumulator / 2^e, truncated toward zero
  function automatic logic signed [WordBits-1:0] cur_value(
    input logic [WordBits-1:0] acc,
    input logic [ExpBits-1:0]  e
  );
    logic [WordBits-1:0]      bias;
    logic signed [WordBits:0] sum;
    bias = (WordBits'(1) << e) - WordBits'(1);
    if (acc[WordBits-1]) begin
      sum = $signed({acc[WordBits-1], acc}) + $signed({1'b0, bias});
    end else begin
      sum = $signed({1'b0, acc});
    end
    return WordBits'(sum >>> e);
  endfunction

  function automatic logic [WordBits:0] abs33(input logic signed [WordBits:0] x);
    return x[WordBits] ? (WordBits+1)'(-x) : (WordBits+1)'(x);
  endfunction

endpackage

// File: design/srlg_front.sv
// ----------------------------------------------------------------------------
// srlg_front
// Accepts command words, decodes and saturates them, queues them for the back.
// ----------------------------------------------------------------------------
module srlg_front #(
  parameter int unsigned Depth = 2
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push,
  output logic                                  full,
  input  logic [1:0]                            kind_i,
  input  logic signed [srlg_pkg::ValueBits-1:0] target_i,
  input  logic [srlg_pkg::MsBits-1:0]           duration_ms_i,
  output srlg_pkg::cmd_t                        cmd_o,
  output logic                                  cmd_valid_o,
  input  logic                                  cmd_pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  srlg_pkg::cmd_t      mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;
  srlg_pkg::cmd_t      cmd_new;
  logic                wr_en, rd_en;

  always_comb begin
    cmd_new.kind   = srlg_pkg::kind_e'(kind_i);
    cmd_new.jump   = (duration_ms_i == '0);
    cmd_new.target = (target_i == srlg_pkg::TargetMin) ? srlg_pkg::TargetSat : target_i;
    cmd_new.ms     = duration_ms_i;
  end

  assign full        = (cnt_q == CntW'(Depth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign wr_en       = push && !full;
  assign rd_en       = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// File: design/srlg_div.sv
// ----------------------------------------------------------------------------
// srlg_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srlg_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srlg_pkg::div_req_t req_i,
  output srlg_pkg::div_rsp_t rsp_o
);

  localparam int unsigned W    = srlg_pkg::WordBits;
  localparam int unsigned RW   = srlg_pkg::StepBits;
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    q_q;
  logic [RW-1:0]   rem_q;
  logic [RW-1:0]   div_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [RW:0]     trial;
  logic            ge;

  assign trial = {rem_q, q_q[W-1]};
  assign ge    = (trial >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      q_q    <= '0;
      rem_q  <= '0;
      div_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(W);
        q_q    <= req_i.dividend;
        rem_q  <= '0;
        div_q  <= req_i.divisor;
      end else if (busy_q) begin
        rem_q <= ge ? RW'(trial - {1'b0, div_q}) : RW'(trial);
        q_q   <= {q_q[W-2:0], ge};
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = q_q;

endmodule

// File: design/srlg_back.sv
// ----------------------------------------------------------------------------
// srlg_back
// Executes queued commands on the ramp state and holds the result word.
// ----------------------------------------------------------------------------
module srlg_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  srlg_pkg::cmd_t                      cmd_i,
  input  logic                                cmd_valid_i,
  output logic                                cmd_pop_o,
  input  logic [srlg_pkg::RateBits-1:0]       rate_i,
  output srlg_pkg::div_req_t                  div_req_o,
  input  srlg_pkg::div_rsp_t                  div_rsp_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [srlg_pkg::ValueBits-1:0] value_o,
  output logic                                done_res_o
);

  localparam int unsigned W    = srlg_pkg::WordBits;
  localparam int unsigned SW   = srlg_pkg::StepBits;
  localparam int unsigned EW   = srlg_pkg::ExpBits;
  localparam int unsigned VW   = srlg_pkg::ValueBits;
  localparam int unsigned TopW = srlg_pkg::TopExp;
  localparam int unsigned RB   = srlg_pkg::RecipBits;
  localparam int unsigned RS   = srlg_pkg::RecipShift;

  typedef enum logic [3:0] {
    StIdle, StCur, StPrep, StLzc, StScale, StDivI, StWaitI, StRes
  } state_e;

  state_e           state_q;
  srlg_pkg::cmd_t   cmd_q;
  logic [W-1:0]     acc_q, fin_q, inc_q;
  logic [SW-1:0]    steps_q;
  logic [EW-1:0]    exp_q, lzc_q;
  logic signed [W-1:0] cur_q;
  logic [W-1:0]     prod_q;
  logic signed [W:0] diff_q;
  logic [TopW-1:0]  sh_q;
  logic [W-1:0]     mag_q;
  logic             neg_q;
  logic [VW-1:0]    res_val_q;
  logic             res_done_q, res_vld_q;

  logic signed [W-1:0] tgt32;
  logic signed [W:0]   diff_d;
  logic [W:0]          mag_or;
  logic signed [W+1:0] sdiff;
  logic [W+1:0]        sdiff_mag;
  logic signed [W-1:0] now_val;
  logic [W+RB-1:0]     steps_prod;
  logic                res_load;

  always_comb begin
    tgt32     = {cmd_q.target[VW-1], cmd_q.target};
    diff_d    = $signed({tgt32[W-1], tgt32}) - $signed({cur_q[W-1], cur_q});
    if (cmd_q.jump) begin
      mag_or = srlg_pkg::abs33({tgt32[W-1], tgt32});
    end else begin
      mag_or = srlg_pkg::abs33(diff_d) | srlg_pkg::abs33({cur_q[W-1], cur_q})
             | srlg_pkg::abs33({tgt32[W-1], tgt32});
    end
    sdiff     = $signed({diff_q[W], diff_q}) <<< lzc_q;
    sdiff_mag = sdiff[W+1] ? (W+2)'(-sdiff) : (W+2)'(sdiff);
    now_val   = srlg_pkg::cur_value(acc_q, exp_q);
    // ms*rate/1000 by reciprocal multiply
    steps_prod = (W+RB)'(prod_q) * (W+RB)'(srlg_pkg::RecipMs);
  end

  assign cmd_pop_o = (state_q == StIdle) && cmd_valid_i;

  assign div_req_o.start    = (state_q == StDivI);
  assign div_req_o.dividend = mag_q;
  assign div_req_o.divisor  = steps_q;

  assign res_load   = (state_q == StRes) && (!res_vld_q || pop);
  assign empty      = !res_vld_q;
  assign value_o    = res_val_q;
  assign done_res_o = res_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      cmd_q      <= '0;
      acc_q      <= '0;
      fin_q      <= '0;
      inc_q      <= '0;
      steps_q    <= '0;
      exp_q      <= '0;
      lzc_q      <= '0;
      cur_q      <= '0;
      prod_q     <= '0;
      diff_q     <= '0;
      sh_q       <= '0;
      mag_q      <= '0;
      neg_q      <= 1'b0;
      res_val_q  <= '0;
      res_done_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (res_load) begin
        res_vld_q <= 1'b1;
      end else if (pop && res_vld_q) begin
        res_vld_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (cmd_valid_i) begin
            cmd_q <= cmd_i;
            unique case (cmd_i.kind)
              srlg_pkg::KindTick: begin
                if (steps_q > SW'(1)) begin
                  acc_q   <= acc_q + inc_q;
                  steps_q <= steps_q - SW'(1);
                end else if (steps_q == SW'(1)) begin
                  acc_q   <= fin_q << exp_q;
                  steps_q <= '0;
                end
                state_q <= StRes;
              end
              srlg_pkg::KindStart: state_q <= StCur;
              srlg_pkg::KindStop: begin
                steps_q <= '0;
                inc_q   <= '0;
                state_q <= StRes;
              end
              srlg_pkg::KindNone: state_q <= StRes;
              default: state_q <= StRes;
            endcase
          end
        end
        StCur: begin
          cur_q   <= now_val;
          prod_q  <= W'(cmd_q.ms) * W'(rate_i);
          fin_q   <= tgt32;
          state_q <= StPrep;
        end
        StPrep: begin
          diff_q  <= diff_d;
          lzc_q   <= '0;
          sh_q    <= mag_or[TopW-1:0];
          steps_q <= steps_prod[RS +: SW] + SW'(1);
          state_q <= (mag_or[W:TopW] != '0) ? StScale : StLzc;
        end
        StLzc: begin
          // one leading-zero position per cycle; all-zero stops at the top exponent
          if (sh_q[TopW-1] || (lzc_q == EW'(srlg_pkg::TopExp))) begin
            state_q <= StScale;
          end else begin
            sh_q  <= sh_q << 1;
            lzc_q <= lzc_q + EW'(1);
          end
        end
        StScale: begin
          exp_q <= lzc_q;
          if (cmd_q.jump) begin
            acc_q   <= tgt32 << lzc_q;
            steps_q <= '0;
            inc_q   <= '0;
            state_q <= StRes;
          end else begin
            acc_q   <= cur_q << lzc_q;
            mag_q   <= sdiff_mag[W-1:0];
            neg_q   <= sdiff[W+1];
            state_q <= StDivI;
          end
        end
        StDivI: state_q <= StWaitI;
        StWaitI: begin
          if (div_rsp_i.done) begin
            inc_q   <= neg_q ? W'(-div_rsp_i.quot) : div_rsp_i.quot;
            state_q <= StRes;
          end
        end
        StRes: begin
          if (res_load) begin
            res_val_q  <= now_val[VW-1:0];
            res_done_q <= (steps_q == '0);
            state_q    <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// File: design/scaled_linear_ramp_generator.sv
// ----------------------------------------------------------------------------
// scaled_linear_ramp_generator
// Setpoint ramp with a power-of-two scaled accumulator, driven by tick,
// start and stop command words.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  --------  ---------  -------------------  --------------------------------
//  command   in         push / full          kind_i, target_i, duration_ms_i
//  result    out        empty / pop          value_o, done_res_o
//  config    in         cfg_we_i (no wait)   cfg_wdata_i = tick rate in Hz
//
//  A tick, stop or unused command goes straight to the result state once taken;
//  its result is registered there when the result slot is free. A start runs
//  a leading-zero scan when needed, then one run of the serial divider (scaled
//  difference / steps); the step count, ms*rate/1000 plus one, comes from a
//  reciprocal multiply. A jump skips the divider.
//  Reset clears all ramp state and the queues at once; no clearing pass.
//  A held result stalls only the back end; the front keeps taking words
//  until its command queue is full.
//
module scaled_linear_ramp_generator #(
  parameter int unsigned CmdDepth = 2
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push,
  output logic                                  full,
  input  logic [1:0]                            kind_i,
  input  logic signed [srlg_pkg::ValueBits-1:0] target_i,
  input  logic [srlg_pkg::MsBits-1:0]           duration_ms_i,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [srlg_pkg::ValueBits-1:0] value_o,
  output logic                                  done_res_o,
  input  logic                                  cfg_we_i,
  input  logic [srlg_pkg::RateBits-1:0]         cfg_wdata_i
);

  // tick rate register
  logic [srlg_pkg::RateBits-1:0] rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= srlg_pkg::RateReset;
    end else if (cfg_we_i) begin
      rate_q <= cfg_wdata_i;
    end
  end

  srlg_pkg::cmd_t     cmd;
  logic               cmd_valid, cmd_pop;
  srlg_pkg::div_req_t div_req;
  srlg_pkg::div_rsp_t div_rsp;

  // front: decode, saturate, queue
  srlg_front #(
    .Depth (CmdDepth)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .kind_i        (kind_i),
    .target_i      (target_i),
    .duration_ms_i (duration_ms_i),
    .cmd_o         (cmd),
    .cmd_valid_o   (cmd_valid),
    .cmd_pop_i     (cmd_pop)
  );

  // back: ramp state and sequencing
  srlg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .rate_i      (rate_q),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .empty       (empty),
    .pop         (pop),
    .value_o     (value_o),
    .done_res_o  (done_res_o)
  );

  // serial divider for the step increment
  srlg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // divider is only started when free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // back never takes a word from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  // an accepted word is visible to the back on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> cmd_valid)
    else $error("accepted command lost");

  // a divider result only arrives while the back waits for one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> $past(div_rsp.busy))
    else $error("divider done without a run");

endmodule
